@@ src/snf_pkg.sv @@
// Shared types, widths and the sigmoid sample table for the sigmoid neuron.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none
package snf_pkg;

    localparam int W_W         = 16;
    localparam int A_W         = 16;
    localparam int B_W         = 16;
    localparam int DATA_IN_W   = W_W + A_W + B_W;
    localparam int PROD_W      = W_W + A_W + 1;
    localparam int ACC_W       = 48;
    localparam int OUT_W       = 16;
    localparam int BIAS_SHIFT  = 8;
    localparam int FRAC_W      = 23;
    localparam int SIG_DEPTH   = 256;
    localparam int IDX_W       = $clog2(SIG_DEPTH + 1);
    localparam int ROM_W       = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int TAYLOR_TERMS = 20;

    localparam logic [63:0] ONE_Q31  = 64'd1 << 31;
    localparam logic [63:0] TAYLOR_T = (64'd8 << 31) / 64'(SIG_DEPTH);

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic signed [B_W-1:0]    bias;
        logic                     last;
    } term_t;

    typedef logic [ROM_W-1:0] rom_t [0:SIG_DEPTH];

    // Shift-subtract long division, evaluated at elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Samples of sigmoid over [0,8] in Q0.16, from e^(-8/D) by Taylor series.
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] den;
        term = ONE_Q31;
        r    = ONE_Q31;
        p    = ONE_Q31;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = udiv64((term * TAYLOR_T) >> 31, 64'(k));
            if ((k & 1) != 0) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int i = 0; i <= SIG_DEPTH; i++) begin
            if (i > 0) begin
                p = (p * r + (ONE_Q31 >> 1)) >> 31;
            end
            den    = ONE_Q31 + p;
            rom[i] = ROM_W'(udiv64((64'd1 << 47) + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam rom_t SIG_ROM = build_rom();

endpackage
`default_nettype wire

@@ src/snf_front.sv @@
// Input side of the sigmoid neuron: takes beats, registers them and forms
// the weight times activation product. Depends on snf_pkg.
`default_nettype none
module snf_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [snf_pkg::DATA_IN_W-1:0] s_tdata,   // weight, activation_value, bias
    input  wire logic                          s_tlast,
    input  wire logic                          q_full,
    output logic                               q_push,
    output snf_pkg::term_t                     q_term
);

    logic                             in_valid_reg;
    logic signed [snf_pkg::W_W-1:0]   weight_reg;
    logic        [snf_pkg::A_W-1:0]   act_reg;
    logic signed [snf_pkg::B_W-1:0]   bias_reg;
    logic                             last_reg;
    logic                             accept;
    logic signed [snf_pkg::PROD_W-1:0] weight_ext;
    logic signed [snf_pkg::PROD_W-1:0] act_ext;

    assign s_tready = !in_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = in_valid_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (q_push) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            weight_reg <= s_tdata[snf_pkg::W_W-1:0];
            act_reg    <= s_tdata[snf_pkg::W_W+snf_pkg::A_W-1:snf_pkg::W_W];
            bias_reg   <= s_tdata[snf_pkg::DATA_IN_W-1:snf_pkg::W_W+snf_pkg::A_W];
            last_reg   <= s_tlast;
        end
    end

    always_comb begin
        weight_ext     = snf_pkg::PROD_W'(weight_reg);
        act_ext        = $signed(snf_pkg::PROD_W'(act_reg));
        q_term.product = weight_ext * act_ext;
        q_term.bias    = bias_reg;
        q_term.last    = last_reg;
    end

endmodule
`default_nettype wire

@@ src/snf_queue.sv @@
// Short first-in first-out queue of product terms between front and back.
// Depends on snf_pkg for the entry type and depth.
`default_nettype none
module snf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire snf_pkg::term_t push_data,
    output logic                full,
    output logic                not_empty,
    input  wire logic           pop,
    output snf_pkg::term_t      pop_data
);

    localparam int PTR_W = $clog2(snf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(snf_pkg::QUEUE_DEPTH + 1);

    snf_pkg::term_t   entry_reg [snf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = count_reg == CNT_W'(snf_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(snf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(snf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(snf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow queue");

endmodule
`default_nettype wire

@@ src/snf_back.sv @@
// Back end of the sigmoid neuron: saturating accumulate, bias add, table
// sigmoid with interpolation and the result register. Depends on snf_pkg.
`default_nettype none
module snf_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  wire snf_pkg::term_t            q_data,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [snf_pkg::OUT_W-1:0]      m_tdata,   // neuron_output
    output logic                           m_tuser    // saturated
);

    localparam int ACC_W = snf_pkg::ACC_W;
    localparam int FRAC_W = snf_pkg::FRAC_W;
    localparam int IDX_W = snf_pkg::IDX_W;
    localparam int ROM_W = snf_pkg::ROM_W;
    localparam int OUT_W = snf_pkg::OUT_W;
    localparam int U_W = FRAC_W + IDX_W;
    localparam int MUL_W = ROM_W + FRAC_W;

    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_BIAS = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_ROM  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic [2:0]                     state_reg, state_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic                           ovf_reg, ovf_next;
    logic signed [snf_pkg::B_W-1:0] bias_reg, bias_next;
    logic                           neg_reg, neg_next;
    logic                           big_reg, big_next;
    logic                           sat_reg, sat_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [FRAC_W-1:0]              frac_reg, frac_next;
    logic [ROM_W-1:0]               lo_reg, lo_next;
    logic [ROM_W-1:0]               hi_reg, hi_next;
    logic [ROM_W-1:0]               interp_reg, interp_next;
    logic                           m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]               m_data_reg, m_data_next;
    logic                           m_user_reg, m_user_next;

    logic signed [ACC_W:0]          addend;
    logic signed [ACC_W:0]          sum;
    logic signed [ACC_W-1:0]        sum_sat;
    logic                           clamp;
    logic [ACC_W-1:0]               mag;
    logic [U_W-1:0]                 u;
    logic [IDX_W-1:0]               idx_raw;
    logic [ROM_W-1:0]               diff;
    logic [MUL_W-1:0]               mul;
    logic [ROM_W:0]                 v_sum;
    logic [OUT_W-1:0]               v16;
    logic [OUT_W-1:0]               v_neg;
    logic [OUT_W-1:0]               result;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        if (state_reg == ST_BIAS) begin
            addend = {{(ACC_W + 1 - snf_pkg::B_W - snf_pkg::BIAS_SHIFT){bias_reg[snf_pkg::B_W-1]}},
                      bias_reg, {snf_pkg::BIAS_SHIFT{1'b0}}};
        end else begin
            addend = {{(ACC_W + 1 - snf_pkg::PROD_W){q_data.product[snf_pkg::PROD_W-1]}},
                      q_data.product};
        end
        sum   = {acc_reg[ACC_W-1], acc_reg} + addend;
        clamp = sum[ACC_W] != sum[ACC_W-1];
        if (clamp) begin
            sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end

        mag     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        u       = {{IDX_W{1'b0}}, mag[FRAC_W-1:0]} * U_W'(snf_pkg::SIG_DEPTH);
        idx_raw = u[U_W-1:FRAC_W];

        diff  = hi_reg - lo_reg;
        mul   = MUL_W'(diff) * MUL_W'(frac_reg);
        v_sum = {1'b0, lo_reg} + {1'b0, interp_reg};
        v16   = (|v_sum[ROM_W:OUT_W]) ? {OUT_W{1'b1}} : v_sum[OUT_W-1:0];
        v_neg = OUT_W'(~v16 + 1'b1);
        if (big_reg) begin
            result = neg_reg ? '0 : {OUT_W{1'b1}};
        end else begin
            result = neg_reg ? v_neg : v16;
        end
    end

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        bias_next    = bias_reg;
        neg_next     = neg_reg;
        big_next     = big_reg;
        sat_next     = sat_reg;
        idx_next     = idx_reg;
        frac_next    = frac_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        interp_next  = interp_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        q_pop        = 1'b0;
        unique case (state_reg)
            ST_ACC: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    acc_next = sum_sat;
                    ovf_next = ovf_reg || clamp;
                    if (q_data.last) begin
                        bias_next  = q_data.bias;
                        state_next = ST_BIAS;
                    end
                end
            end
            ST_BIAS: begin
                acc_next   = sum_sat;
                ovf_next   = ovf_reg || clamp;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                neg_next   = acc_reg[ACC_W-1];
                big_next   = |mag[ACC_W-1:FRAC_W];
                idx_next   = (idx_raw >= IDX_W'(snf_pkg::SIG_DEPTH)) ?
                             IDX_W'(snf_pkg::SIG_DEPTH - 1) : idx_raw;
                frac_next  = u[FRAC_W-1:0];
                sat_next   = ovf_reg;
                acc_next   = '0;
                ovf_next   = 1'b0;
                state_next = ST_ROM;
            end
            ST_ROM: begin
                lo_next    = snf_pkg::SIG_ROM[idx_reg];
                hi_next    = snf_pkg::SIG_ROM[idx_reg + 1'b1];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                interp_next = mul[MUL_W-1:FRAC_W];
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    m_user_next  = sat_reg;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bias_reg   <= bias_next;
        neg_reg    <= neg_next;
        big_reg    <= big_next;
        sat_reg    <= sat_next;
        idx_reg    <= idx_next;
        frac_reg   <= frac_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        interp_reg <= interp_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && m_valid_reg && !m_tready |=> state_reg == ST_FIN)
        else $error("result overwritten while receiver stalled");

    a_clear_after_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ABS |=> acc_reg == '0 && !ovf_reg)
        else $error("accumulator not cleared after neuron");

    a_pop_only_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_ACC && q_valid)
        else $error("queue popped outside accumulate");

endmodule
`default_nettype wire

@@ src/sigmoid_neuron_forward.sv @@
// Sigmoid neuron forward value: top level joining front, queue and back.
// Depends on snf_pkg, snf_front, snf_queue and snf_back.
//
// Usage:
//   Slave channel: one beat per weight and activation pair. s_tdata holds
//   weight (Q4.12) in [15:0], activation (Q8.8) in [31:16] and bias (Q4.12)
//   in [47:32]; s_tlast marks the final term of a neuron, whose bias is added.
//   Master channel: one beat per neuron, m_tdata[15:0] is the sigmoid in
//   Q0.16 and m_tuser flags that the 48-bit accumulator clamped.
//   Throughput: one non-last beat per cycle while the queue is not full; a
//   last beat holds the back end through accumulate, bias add, magnitude
//   and index, table read, interpolation multiply and result, which sets the
//   rate per neuron. m_tvalid rises once that last beat has passed the
//   front register, the queue and these back end steps.
//   A four-entry queue lets the input keep taking beats while a result
//   waits; when the receiver stalls, the result register holds and the
//   back end waits with the next result, then the queue fills and s_tready
//   drops.
//   Reset clears the accumulator, the overflow flag, the queue and the
//   output valid; no clearing pass is needed.
`default_nettype none
module sigmoid_neuron_forward (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [snf_pkg::DATA_IN_W-1:0] s_tdata,   // weight, activation_value, bias
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [snf_pkg::OUT_W-1:0]          m_tdata,   // neuron_output
    output logic                               m_tuser    // saturated
);

    logic           q_push;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    snf_pkg::term_t q_in;
    snf_pkg::term_t q_out;

    snf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_term   (q_in)
    );

    snf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    snf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
